@@ sv/broken_down_time_to_epoch_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BROKEN_DOWN_TIME_TO_EPOCH_ASSERT_SVH
`define BROKEN_DOWN_TIME_TO_EPOCH_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define BDTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked check that also holds during reset.
`define BDTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/bdte_pkg.sv @@
package bdte_pkg;

  // Datapath operations, one per sequencer step.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEC_Q,
    OP_SEC_R,
    OP_MIN_Q,
    OP_MIN_R,
    OP_HOUR_Q,
    OP_HOUR_R,
    OP_MON_Q,
    OP_MON_R,
    OP_FWD,
    OP_BACK,
    OP_YDAY,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_Y1,
    OP_Y2
  } dp_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic day_over;
    logic day_under;
  } dp_sts_t;

  localparam logic [3:0] MONTH_LAST = 4'd11;

  // Reciprocal division: q = ((x + 64*d) * M) >> DIV_SHIFT, minus 64.
  localparam int unsigned DIV_SHIFT = 19;
  localparam logic [6:0]  DIV_SEC   = 7'd60;
  localparam logic [6:0]  DIV_HOUR  = 7'd24;
  localparam logic [6:0]  DIV_MON   = 7'd12;
  localparam logic [15:0] RECIP_SEC  = 16'd8739;
  localparam logic [15:0] RECIP_HOUR = 16'd21846;
  localparam logic [15:0] RECIP_MON  = 16'd43691;
  localparam logic [13:0] BIAS_SEC   = 14'd3840;
  localparam logic [13:0] BIAS_HOUR  = 14'd1536;
  localparam logic [13:0] BIAS_MON   = 14'd768;
  localparam logic [7:0]  BIAS_Q     = 8'd64;

  localparam logic [24:0] SECS_PER_MIN  = 25'd60;
  localparam logic [24:0] HOURS_PER_DAY = 25'd24;
  localparam logic signed [33:0] SECS_PER_YEAR = 34'sd31536000;
  localparam logic signed [33:0] SECS_PER_DAY  = 34'sd86400;
  localparam logic signed [10:0] EPOCH_YEAR    = 11'sd70;
  localparam logic signed [10:0] LEAP_BASE     = 11'sd69;

  function automatic logic [4:0] bdte_month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before mon, in a common year.
  function automatic logic [8:0] bdte_days_before(input logic [3:0] mon);
    logic [8:0] days;
    unique case (mon)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      default: days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

@@ sv/bdte_ctrl.sv @@
module bdte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  bdte_pkg::dp_sts_t sts_i,
  output bdte_pkg::dp_op_e  op_o
);
  import bdte_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SEC_Q  = 5'd1;
  localparam logic [4:0] ST_SEC_R  = 5'd2;
  localparam logic [4:0] ST_MIN_Q  = 5'd3;
  localparam logic [4:0] ST_MIN_R  = 5'd4;
  localparam logic [4:0] ST_HOUR_Q = 5'd5;
  localparam logic [4:0] ST_HOUR_R = 5'd6;
  localparam logic [4:0] ST_MON_Q  = 5'd7;
  localparam logic [4:0] ST_MON_R  = 5'd8;
  localparam logic [4:0] ST_FWD    = 5'd9;
  localparam logic [4:0] ST_BACK   = 5'd10;
  localparam logic [4:0] ST_YDAY   = 5'd11;
  localparam logic [4:0] ST_T1     = 5'd12;
  localparam logic [4:0] ST_T2     = 5'd13;
  localparam logic [4:0] ST_T3     = 5'd14;
  localparam logic [4:0] ST_Y1     = 5'd15;
  localparam logic [4:0] ST_Y2     = 5'd16;
  localparam logic [4:0] ST_DONE   = 5'd17;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = ST_SEC_Q;
        end
      end
      ST_SEC_Q:  begin op_o = OP_SEC_Q;  state_d = ST_SEC_R;  end
      ST_SEC_R:  begin op_o = OP_SEC_R;  state_d = ST_MIN_Q;  end
      ST_MIN_Q:  begin op_o = OP_MIN_Q;  state_d = ST_MIN_R;  end
      ST_MIN_R:  begin op_o = OP_MIN_R;  state_d = ST_HOUR_Q; end
      ST_HOUR_Q: begin op_o = OP_HOUR_Q; state_d = ST_HOUR_R; end
      ST_HOUR_R: begin op_o = OP_HOUR_R; state_d = ST_MON_Q;  end
      ST_MON_Q:  begin op_o = OP_MON_Q;  state_d = ST_MON_R;  end
      ST_MON_R:  begin op_o = OP_MON_R;  state_d = ST_FWD;    end
      ST_FWD: begin
        op_o = OP_FWD;
        if (!sts_i.day_over) begin
          state_d = ST_BACK;
        end
      end
      ST_BACK: begin
        op_o = OP_BACK;
        if (!sts_i.day_under) begin
          state_d = ST_YDAY;
        end
      end
      ST_YDAY:   begin op_o = OP_YDAY;   state_d = ST_T1;     end
      ST_T1:     begin op_o = OP_T1;     state_d = ST_T2;     end
      ST_T2:     begin op_o = OP_T2;     state_d = ST_T3;     end
      ST_T3:     begin op_o = OP_T3;     state_d = ST_Y1;     end
      ST_Y1:     begin op_o = OP_Y1;     state_d = ST_Y2;     end
      ST_Y2:     begin op_o = OP_Y2;     state_d = ST_DONE;   end
      ST_DONE:   begin                   state_d = ST_IDLE;   end
      default:   begin                   state_d = ST_IDLE;   end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

@@ sv/bdte_datapath.sv @@
module bdte_datapath (
  input  logic                     clk_i,
  input  bdte_pkg::dp_op_e         op_i,
  input  logic signed [10:0]       second_in_i,
  input  logic signed [10:0]       minute_in_i,
  input  logic signed [10:0]       hour_in_i,
  input  logic signed [10:0]       day_in_i,
  input  logic signed [7:0]        month_in_i,
  input  logic        [7:0]        year_in_i,
  output bdte_pkg::dp_sts_t        sts_o,
  output logic        [5:0]        second_out_o,
  output logic        [5:0]        minute_out_o,
  output logic        [4:0]        hour_out_o,
  output logic        [4:0]        day_out_o,
  output logic        [3:0]        month_out_o,
  output logic signed [9:0]        year_out_o,
  output logic        [8:0]        day_of_year_o,
  output logic signed [33:0]       epoch_seconds_o
);
  import bdte_pkg::*;

  typedef enum logic [1:0] {
    SEL_SEC,
    SEL_MIN,
    SEL_HOUR,
    SEL_MON
  } div_sel_e;

  logic signed [12:0] sec_q, sec_d, min_q, min_d, hour_q, hour_d, mday_q, mday_d;
  logic signed [7:0]  mon_q, mon_d, q_q, q_d;
  logic signed [9:0]  year_q, year_d;
  logic        [8:0]  yday_q, yday_d;
  logic        [24:0] t_q, t_d;
  logic signed [33:0] acc_q, acc_d;

  div_sel_e           sel;
  logic signed [12:0] div_x;
  logic        [6:0]  div_k;
  logic        [15:0] recip;
  logic        [13:0] bias;
  logic        [13:0] x_biased;
  logic        [28:0] prod;
  logic signed [7:0]  q_div;
  logic signed [12:0] qk;
  logic signed [12:0] rem;

  logic               leap;
  logic        [4:0]  len_cur;
  logic        [3:0]  prev_mon;
  logic signed [9:0]  prev_year;
  logic        [4:0]  len_prev;
  logic signed [10:0] yr_rel70;
  logic signed [10:0] yr_rel69;
  logic signed [10:0] leap_days;

  // Select the field that the shared constant divider works on.
  always_comb begin
    unique case (op_i)
      OP_SEC_Q, OP_SEC_R:   sel = SEL_SEC;
      OP_MIN_Q, OP_MIN_R:   sel = SEL_MIN;
      OP_HOUR_Q, OP_HOUR_R: sel = SEL_HOUR;
      default:              sel = SEL_MON;
    endcase
    unique case (sel)
      SEL_SEC:  begin div_x = sec_q;  div_k = DIV_SEC;  recip = RECIP_SEC;  bias = BIAS_SEC;  end
      SEL_MIN:  begin div_x = min_q;  div_k = DIV_SEC;  recip = RECIP_SEC;  bias = BIAS_SEC;  end
      SEL_HOUR: begin div_x = hour_q; div_k = DIV_HOUR; recip = RECIP_HOUR; bias = BIAS_HOUR; end
      default:  begin
        div_x = {{5{mon_q[7]}}, mon_q};
        div_k = DIV_MON;
        recip = RECIP_MON;
        bias  = BIAS_MON;
      end
    endcase
  end

  // Bias to a non-negative value so the reciprocal gives a floor quotient.
  assign x_biased = {div_x[12], div_x} + bias;
  assign prod     = x_biased[12:0] * recip;
  assign q_div    = {1'b0, prod[DIV_SHIFT+6:DIV_SHIFT]} - BIAS_Q;
  assign qk       = $signed({{5{q_q[7]}}, q_q}) * $signed({6'd0, div_k});
  assign rem      = div_x - qk;

  assign leap      = (year_q[1:0] == 2'b00);
  assign len_cur   = bdte_month_len(mon_q[3:0], leap);
  assign prev_mon  = (mon_q[3:0] == 4'd0) ? MONTH_LAST : (mon_q[3:0] - 4'd1);
  assign prev_year = (mon_q[3:0] == 4'd0) ? (year_q - 10'sd1) : year_q;
  assign len_prev  = bdte_month_len(prev_mon, prev_year[1:0] == 2'b00);

  assign sts_o.day_over  = (mday_q > $signed({8'd0, len_cur}));
  assign sts_o.day_under = mday_q[12] || (mday_q == 13'sd0);

  assign yr_rel70  = {year_q[9], year_q} - EPOCH_YEAR;
  assign yr_rel69  = {year_q[9], year_q} - LEAP_BASE;
  // Truncating division by four: round negative values toward zero.
  assign leap_days = yr_rel69[10] ? ((yr_rel69 + 11'sd3) >>> 2) : (yr_rel69 >>> 2);

  always_comb begin
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    mday_d = mday_q;
    mon_d  = mon_q;
    year_d = year_q;
    q_d    = q_q;
    yday_d = yday_q;
    t_d    = t_q;
    acc_d  = acc_q;
    unique case (op_i)
      OP_LOAD: begin
        sec_d  = {{2{second_in_i[10]}}, second_in_i};
        min_d  = {{2{minute_in_i[10]}}, minute_in_i};
        hour_d = {{2{hour_in_i[10]}}, hour_in_i};
        mday_d = {{2{day_in_i[10]}}, day_in_i};
        mon_d  = month_in_i;
        year_d = {2'b00, year_in_i};
      end
      OP_SEC_Q, OP_MIN_Q, OP_HOUR_Q, OP_MON_Q: q_d = q_div;
      OP_SEC_R: begin
        sec_d = rem;
        min_d = min_q + {{5{q_q[7]}}, q_q};
      end
      OP_MIN_R: begin
        min_d  = rem;
        hour_d = hour_q + {{5{q_q[7]}}, q_q};
      end
      OP_HOUR_R: begin
        hour_d = rem;
        mday_d = mday_q + {{5{q_q[7]}}, q_q};
      end
      OP_MON_R: begin
        mon_d  = rem[7:0];
        year_d = year_q + {{2{q_q[7]}}, q_q};
      end
      OP_FWD: begin
        if (sts_o.day_over) begin
          mday_d = mday_q - $signed({8'd0, len_cur});
          if (mon_q[3:0] == MONTH_LAST) begin
            mon_d  = 8'sd0;
            year_d = year_q + 10'sd1;
          end else begin
            mon_d = mon_q + 8'sd1;
          end
        end
      end
      OP_BACK: begin
        if (sts_o.day_under) begin
          mon_d  = {4'd0, prev_mon};
          year_d = prev_year;
          mday_d = mday_q + $signed({8'd0, len_prev});
        end
      end
      OP_YDAY: begin
        yday_d = bdte_days_before(mon_q[3:0])
               + {8'd0, (leap && (mon_q[3:0] > 4'd1))}
               + mday_q[8:0] - 9'd1;
      end
      OP_T1: t_d = {20'd0, hour_q[4:0]} + {16'd0, yday_q} * HOURS_PER_DAY;
      OP_T2: t_d = t_q * SECS_PER_MIN + {19'd0, min_q[5:0]};
      OP_T3: t_d = t_q * SECS_PER_MIN + {19'd0, sec_q[5:0]};
      OP_Y1: acc_d = 34'(yr_rel70) * SECS_PER_YEAR + $signed({9'd0, t_q});
      OP_Y2: acc_d = acc_q + 34'(leap_days) * SECS_PER_DAY;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    mday_q <= mday_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    q_q    <= q_d;
    yday_q <= yday_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
  end

  assign second_out_o    = sec_q[5:0];
  assign minute_out_o    = min_q[5:0];
  assign hour_out_o      = hour_q[4:0];
  assign day_out_o       = mday_q[4:0];
  assign month_out_o     = mon_q[3:0];
  assign year_out_o      = year_q;
  assign day_of_year_o   = yday_q;
  assign epoch_seconds_o = acc_q;

endmodule

@@ sv/broken_down_time_to_epoch.sv @@
// Broken-down time to epoch seconds. A transfer starts at a rising edge with
// start high and busy low; busy then stays high until the result is shown.
// The result is marked by done_o, high for exactly one cycle, and the
// receiver cannot stall it: capture it in that cycle. The field ports hold
// the result until the next accepted start. A conversion runs the floor
// divisions by 60, 60, 24 and 12 through one shared reciprocal multiplier,
// each as a quotient step and a remainder step, then fits the day into its
// month by stepping months forward and backward (no steps for in-range
// dates), one month per cycle, and ends with the day of year and the
// seconds accumulation. A new start is taken in the cycle after done_o.
module broken_down_time_to_epoch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [10:0] second_in_i,
  input  logic signed [10:0] minute_in_i,
  input  logic signed [10:0] hour_in_i,
  input  logic signed [10:0] day_in_i,
  input  logic signed [7:0]  month_in_i,
  input  logic        [7:0]  year_in_i,
  output logic               done_o,
  output logic        [5:0]  second_out_o,
  output logic        [5:0]  minute_out_o,
  output logic        [4:0]  hour_out_o,
  output logic        [4:0]  day_out_o,
  output logic        [3:0]  month_out_o,
  output logic signed [9:0]  year_out_o,
  output logic        [8:0]  day_of_year_o,
  output logic signed [33:0] epoch_seconds_o
);
  import bdte_pkg::*;

  dp_op_e  op;
  dp_sts_t sts;

  // Sequencer: steps through the carries, loops on the day fit, then forms the day of year and the seconds.
  bdte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .op_o   (op)
  );

  // Datapath: working registers double as the result registers.
  bdte_datapath u_datapath (
    .clk_i           (clk_i),
    .op_i            (op),
    .second_in_i     (second_in_i),
    .minute_in_i     (minute_in_i),
    .hour_in_i       (hour_in_i),
    .day_in_i        (day_in_i),
    .month_in_i      (month_in_i),
    .year_in_i       (year_in_i),
    .sts_o           (sts),
    .second_out_o    (second_out_o),
    .minute_out_o    (minute_out_o),
    .hour_out_o      (hour_out_o),
    .day_out_o       (day_out_o),
    .month_out_o     (month_out_o),
    .year_out_o      (year_out_o),
    .day_of_year_o   (day_of_year_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

endmodule

@@ sv/bdte_checker.sv @@
`include "broken_down_time_to_epoch_assert.svh"

module bdte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic        [5:0]  second_out_o,
  input logic        [5:0]  minute_out_o,
  input logic        [4:0]  hour_out_o,
  input logic        [4:0]  day_out_o,
  input logic        [3:0]  month_out_o,
  input logic        [8:0]  day_of_year_o
);

  // A result only ends a transfer that is in flight.
  `BDTE_ASSERT_ALWAYS(a_done_busy, done_o |-> busy, "done_o without busy")

  // An accepted start makes the block busy.
  `BDTE_ASSERT(a_start_busy, (start && !busy) |=> busy, "start accepted but not busy")

  // The strobe lasts one cycle, and the block frees up right after it.
  `BDTE_ASSERT(a_done_pulse, done_o |=> (!done_o && !busy), "done_o longer than one cycle")

  // Every result is normalized.
  `BDTE_ASSERT(a_fields_range,
    done_o |-> ((second_out_o < 6'd60) && (minute_out_o < 6'd60) && (hour_out_o < 5'd24)
                && (day_out_o != 5'd0) && (month_out_o < 4'd12) && (day_of_year_o < 9'd366)),
    "result field out of range")

endmodule

bind broken_down_time_to_epoch bdte_checker u_bdte_checker (.*);

@@ sim/tb_broken_down_time_to_epoch.sv @@
`timescale 1ns / 100ps

module tb_broken_down_time_to_epoch;

  import bdte_pkg::*;

  // Cycles with neither an input transfer nor a result before the run is abandoned.
  // This leaves a wide margin over the slowest conversion.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last result before the verdict.
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1100;
  // No input idling while the transfer count is inside this window.
  localparam int CALM_FROM = 300;
  localparam int CALM_TO = 500;
  // Every DRAIN_EVERY transfers, hold the next start until the result is back.
  localparam int DRAIN_EVERY = 250;
  localparam int IDLE_PERCENT = 19;

  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One broken-down time as it goes into the block.
  typedef struct {
    logic signed [10:0] sec;
    logic signed [10:0] minute;
    logic signed [10:0] hr;
    logic signed [10:0] mday;
    logic signed [7:0]  mon;
    logic        [7:0]  yr;
  } datetime_t;

  // Normalized time and epoch seconds as the block reports them.
  typedef struct {
    logic        [5:0]  sec;
    logic        [5:0]  minute;
    logic        [4:0]  hr;
    logic        [4:0]  mday;
    logic        [3:0]  mon;
    logic signed [9:0]  yr;
    logic        [8:0]  yday;
    logic signed [33:0] epoch;
  } norm_time_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic signed [10:0] second_in_i = '0;
  logic signed [10:0] minute_in_i = '0;
  logic signed [10:0] hour_in_i = '0;
  logic signed [10:0] day_in_i = '0;
  logic signed [7:0]  month_in_i = '0;
  logic        [7:0]  year_in_i = '0;
  logic               done_o;
  logic        [5:0]  second_out_o;
  logic        [5:0]  minute_out_o;
  logic        [4:0]  hour_out_o;
  logic        [4:0]  day_out_o;
  logic        [3:0]  month_out_o;
  logic signed [9:0]  year_out_o;
  logic        [8:0]  day_of_year_o;
  logic signed [33:0] epoch_seconds_o;

  datetime_t  pending_times[$];
  norm_time_t expected_times[$];

  int errors = 0;
  int n_sent = 0;
  int in_flight = 0;
  int stall_cycles = 0;
  bit draining = 1'b0;

  always #1 clk_i = ~clk_i;

  broken_down_time_to_epoch DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .second_in_i    (second_in_i),
    .minute_in_i    (minute_in_i),
    .hour_in_i      (hour_in_i),
    .day_in_i       (day_in_i),
    .month_in_i     (month_in_i),
    .year_in_i      (year_in_i),
    .done_o         (done_o),
    .second_out_o   (second_out_o),
    .minute_out_o   (minute_out_o),
    .hour_out_o     (hour_out_o),
    .day_out_o      (day_out_o),
    .month_out_o    (month_out_o),
    .year_out_o     (year_out_o),
    .day_of_year_o  (day_of_year_o),
    .epoch_seconds_o(epoch_seconds_o)
  );

  // Floor division by a positive divisor; the remainder is always 0..den-1.
  function automatic longint floor_div(input longint num, input longint den,
                                       output longint rem);
    longint q;
    q = num / den;
    rem = num % den;
    if (rem < 0) begin
      rem += den;
      q--;
    end
    return q;
  endfunction

  // Length of a month; every fourth year (counted from 1900) is a leap year.
  function automatic longint month_length(input longint mon, input longint yr);
    if (mon == 1 && yr % 4 == 0) return 29;
    return DAYS_IN_MONTH[mon];
  endfunction

  // Normalize a broken-down time and convert it to seconds since 1970.
  function automatic norm_time_t normalize_time(input datetime_t t);
    norm_time_t res;
    longint s, mi, h, d, mo, y, yday, secs, rem, i;
    s = t.sec;
    mi = t.minute;
    h = t.hr;
    d = t.mday;
    mo = t.mon;
    y = t.yr;
    // Carry upward with floor semantics so negative fields borrow.
    mi += floor_div(s, 60, rem);
    s = rem;
    h += floor_div(mi, 60, rem);
    mi = rem;
    d += floor_div(h, 24, rem);
    h = rem;
    y += floor_div(mo, 12, rem);
    mo = rem;
    // Walk the day into its month, one month at a time.
    while (d > month_length(mo, y)) begin
      d -= month_length(mo, y);
      mo++;
      if (mo >= 12) begin
        mo = 0;
        y++;
      end
    end
    // Going back: wrap the month first, then read the length in the new year.
    while (d <= 0) begin
      mo--;
      if (mo < 0) begin
        mo = 11;
        y--;
      end
      d += month_length(mo, y);
    end
    yday = 0;
    for (i = 0; i < mo; i++) yday += month_length(i, y);
    yday += d - 1;
    secs = s + 60 * (mi + 60 * (h + 24 * yday));
    secs += (y - 70) * 365 * 86400;
    // Leap days before the year: division truncates toward zero here.
    secs += ((y - 69) / 4) * 86400;
    res.sec = s[5:0];
    res.minute = mi[5:0];
    res.hr = h[4:0];
    res.mday = d[4:0];
    res.mon = mo[3:0];
    res.yr = y[9:0];
    res.yday = yday[8:0];
    res.epoch = secs[33:0];
    return res;
  endfunction

  function automatic datetime_t make_time(input int s, input int mi, input int h,
                                          input int d, input int mo, input int y);
    datetime_t t;
    t.sec = s[10:0];
    t.minute = mi[10:0];
    t.hr = h[10:0];
    t.mday = d[10:0];
    t.mon = mo[7:0];
    t.yr = y[7:0];
    return t;
  endfunction

  // Half in-range fields, a quarter near the edges, the rest raw bits.
  function automatic datetime_t random_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)
      return make_time($urandom_range(59), $urandom_range(59), $urandom_range(23),
                       1 + $urandom_range(30), $urandom_range(11), $urandom_range(255));
    if (pick < 75)
      return make_time(int'($urandom_range(299)) - 120, int'($urandom_range(299)) - 120,
                       int'($urandom_range(99)) - 40, int'($urandom_range(110)) - 40,
                       int'($urandom_range(59)) - 24, $urandom_range(255));
    return make_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: present the oldest pending time, advance on each input transfer.
  always @(posedge clk_i) begin : drive_proc
    bit took;
    bit go;
    int flight;
    if (!rst_ni) begin
      start <= 1'b0;
      in_flight <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_times.push_back(normalize_time(pending_times[0]));
        pending_times.pop_front();
        n_sent++;
        if (n_sent % DRAIN_EVERY == 0) draining = 1'b1;
      end
      // Track outstanding conversions from sampled handshakes only.
      flight = in_flight + int'(took) - int'(done_o);
      if (draining && flight == 0) draining = 1'b0;
      go = pending_times.size() != 0 && !draining &&
           ((n_sent >= CALM_FROM && n_sent < CALM_TO) ||
            $urandom_range(99) >= IDLE_PERCENT);
      start <= go;
      if (pending_times.size() != 0) begin
        second_in_i <= pending_times[0].sec;
        minute_in_i <= pending_times[0].minute;
        hour_in_i <= pending_times[0].hr;
        day_in_i <= pending_times[0].mday;
        month_in_i <= pending_times[0].mon;
        year_in_i <= pending_times[0].yr;
      end
      in_flight <= flight;
    end
  end

  // Monitor: capture each result in its strobe cycle and compare it to the oldest prediction.
  always @(posedge clk_i) begin : monitor_proc
    norm_time_t want;
    if (rst_ni && done_o) begin
      if (expected_times.size() == 0) begin
        $display("%0t: result with no conversion outstanding: epoch %0d", $time,
                 epoch_seconds_o);
        errors++;
      end else begin
        want = expected_times.pop_front();
        check_field("second_out", want.sec, second_out_o);
        check_field("minute_out", want.minute, minute_out_o);
        check_field("hour_out", want.hr, hour_out_o);
        check_field("day_out", want.mday, day_out_o);
        check_field("month_out", want.mon, month_out_o);
        check_field("year_out", want.yr, year_out_o);
        check_field("day_of_year", want.yday, day_of_year_o);
        check_field("epoch_seconds", want.epoch, epoch_seconds_o);
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    // Extremes of every field.
    pending_times.push_back(make_time(0, 0, 0, 0, 0, 0));
    pending_times.push_back(make_time(1023, 1023, 1023, 1023, 127, 255));
    pending_times.push_back(make_time(-1024, -1024, -1024, -1024, -128, 0));
    pending_times.push_back(make_time(-1024, 1023, -1024, 1023, -128, 255));
    pending_times.push_back(make_time(1023, -1024, 1023, -1024, 127, 0));
    // Negative carries: one second before midnight borrows all the way up.
    pending_times.push_back(make_time(-1, 0, 0, 1, 0, 70));
    pending_times.push_back(make_time(0, -1, -1, 1, -1, 100));
    // Leap February under the divisible-by-four rule, 1900 included.
    pending_times.push_back(make_time(0, 0, 0, 29, 1, 0));
    pending_times.push_back(make_time(0, 0, 0, 29, 1, 1));
    pending_times.push_back(make_time(0, 0, 0, 0, 2, 4));
    pending_times.push_back(make_time(0, 0, 0, -30, 2, 4));
    // Stepping back across a year boundary into a leap year.
    pending_times.push_back(make_time(0, 0, 0, 0, 0, 5));
    pending_times.push_back(make_time(0, 0, 0, -334, 0, 5));
    pending_times.push_back(make_time(0, 0, 0, -30, 0, 1));
    // Around the epoch and the truncating leap-day count before 1970.
    pending_times.push_back(make_time(0, 0, 0, 1, 0, 70));
    pending_times.push_back(make_time(59, 59, 23, 31, 11, 69));
    pending_times.push_back(make_time(0, 0, 0, 1, 0, 66));
    pending_times.push_back(make_time(0, 0, 0, 1, 0, 65));
    pending_times.push_back(make_time(0, 0, 0, 1, 0, 68));
    pending_times.push_back(make_time(0, 0, 0, 1, 0, 73));
    // Month field wrapping both ways.
    pending_times.push_back(make_time(0, 0, 0, 31, 12, 70));
    pending_times.push_back(make_time(0, 0, 0, 31, -1, 70));
    pending_times.push_back(make_time(60, 60, 24, 32, 11, 255));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_times.push_back(random_time());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Poll on the falling edge so the queues are stable when read.
    while (pending_times.size() != 0 || expected_times.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bdte_pkg.sv
sv/bdte_ctrl.sv
sv/bdte_datapath.sv
sv/broken_down_time_to_epoch.sv
sv/bdte_checker.sv
sim/tb_broken_down_time_to_epoch.sv
